// ----- src/mec_pkg.sv -----
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types, codes and helpers of the escape-time colorizer.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int OPCODE_W  = 2;
    localparam int COLUMN_W  = 10;
    localparam int ROW_W     = 9;
    localparam int COORD_W   = 64;
    localparam int ZF_W      = 16;
    localparam int ITER_W    = 12;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 3;
    // Wide signed working width for sums that are saturated back to 64 bits
    localparam int SAT_W     = 130;

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_RENDER  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ZOOM    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_CENTER_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_CENTER_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RE_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RE_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IM_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IM_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_FACTOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER       = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] zoom_center_re;
        logic signed [COORD_W-1:0] zoom_center_im;
        logic signed [COORD_W-1:0] start_re_min;
        logic signed [COORD_W-1:0] start_re_max;
        logic signed [COORD_W-1:0] start_im_min;
        logic signed [COORD_W-1:0] start_im_max;
        logic [ZF_W-1:0]           zoom_factor;
        logic [ITER_W-1:0]         max_iter;
    } cfg_t;

    // Register contents after reset for a given number of fraction bits
    function automatic cfg_t cfg_reset(input int f);
        cfg_t c;
        c.zoom_center_re = '0;
        c.zoom_center_im = 64'(1) << f;
        c.start_re_min   = 64'(0) - (64'(5) << (f - 1));
        c.start_re_max   = 64'(1) << f;
        c.start_im_min   = 64'(0) - (64'(3) << (f - 1));
        c.start_im_max   = 64'(3) << (f - 1);
        c.zoom_factor    = 16'd58982;
        c.max_iter       = 12'd50;
        return c;
    endfunction

    // Sign-extend a coordinate to the working width
    function automatic logic signed [SAT_W-1:0] sx64(input logic signed [COORD_W-1:0] v);
        return {{(SAT_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // Clamp a wide signed value to the 64-bit signed range
    function automatic logic signed [COORD_W-1:0] sat64(input logic signed [SAT_W-1:0] v);
        logic fits;
        fits = (v[SAT_W-1:COORD_W-1] == '0) || (v[SAT_W-1:COORD_W-1] == '1);
        if (fits) begin
            return v[COORD_W-1:0];
        end
        return v[SAT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    // Magnitude of a signed coordinate as an unsigned value
    function automatic logic [COORD_W-1:0] abs64(input logic signed [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + 64'd1) : v;
    endfunction

endpackage

// ----- src/mandelbrot_escape_colorizer.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_colorizer
// Escape-time pixel colorizer with a zoomable view window.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat carries an opcode (render, zoom, restart) and,
// for render, a column and a row. Opcode 3 is taken and discarded.
// Result channel m_*: one beat per render with red, green, blue and the
// escape count. Zoom and restart give no beat.
// Configuration: cfg_wr_en / cfg_wr_idx / cfg_wr_data write a register;
// write only while no work is pending.
// Work per render: two coordinate divisions by the image size (reciprocal
// multiply, five 16-bit digits each), one 76-step scale division on the
// serial divider, and per iteration three 64x64 products on the shared
// 32x32 multiplier. A zero limit skips the iterations and the division.
// Zoom moves the four view bounds one after another; restart reloads all
// four at once.
// Items are carried out one at a time; a two-entry queue keeps s_ready
// high while the back end works, and a finished pixel waits in the output
// register while the next item already runs.
// Reset (aresetn low, synchronous) restores all registers and the view
// to their defaults and empties the queue. A stalled m_ready holds the
// pixel and, once the queue fills, drops s_ready.
// ----------------------------------------------------------------------------
module mandelbrot_escape_colorizer
    import mec_pkg::*;
#(
    parameter int IMAGE_WIDTH   = 640,
    parameter int IMAGE_HEIGHT  = 480,
    parameter int FRACTION_BITS = 60
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_idx,
    input  logic [COORD_W-1:0]   cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OPCODE_W-1:0]  s_opcode,
    input  logic [COLUMN_W-1:0]  s_column,
    input  logic [ROW_W-1:0]     s_row,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COLOR_W-1:0]   m_red,
    output logic [COLOR_W-1:0]   m_green,
    output logic [COLOR_W-1:0]   m_blue,
    output logic [ITER_W-1:0]    m_escape_count
);

    localparam cfg_t CFG_RST = cfg_reset(FRACTION_BITS);

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid, q_ready;
    item_t q_item;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_idx)
                CFG_ZOOM_CENTER_RE: cfg_next.zoom_center_re = cfg_wr_data;
                CFG_ZOOM_CENTER_IM: cfg_next.zoom_center_im = cfg_wr_data;
                CFG_START_RE_MIN:   cfg_next.start_re_min   = cfg_wr_data;
                CFG_START_RE_MAX:   cfg_next.start_re_max   = cfg_wr_data;
                CFG_START_IM_MIN:   cfg_next.start_im_min   = cfg_wr_data;
                CFG_START_IM_MAX:   cfg_next.start_im_max   = cfg_wr_data;
                CFG_ZOOM_FACTOR:    cfg_next.zoom_factor    = cfg_wr_data[ZF_W-1:0];
                CFG_MAX_ITER:       cfg_next.max_iter       = cfg_wr_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mec_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_column (s_column),
        .s_row    (s_row),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready)
    );

    mec_back #(
        .IMAGE_WIDTH   (IMAGE_WIDTH),
        .IMAGE_HEIGHT  (IMAGE_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_ready   (q_ready),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res_red   (m_red),
        .res_green (m_green),
        .res_blue  (m_blue),
        .res_count (m_escape_count)
    );

    // The count never passes the iteration limit
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_escape_count <= cfg_reg.max_iter))
        else $error("escape count beyond iteration limit");

    // Immediate escape or no iterations gives full color
    a_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_escape_count == '0)) |->
            ((m_blue == 8'hFF) && (m_green == 8'hFF) && (m_red == 8'hFF)))
        else $error("zero count without full color");

    // A pixel that never escapes is black
    a_no_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (cfg_reg.max_iter != '0) && (m_escape_count == cfg_reg.max_iter))
            |-> ((m_blue == '0) && (m_green == '0) && (m_red == '0)))
        else $error("non-escaping pixel not black");

endmodule

// ----- src/mec_mul.sv -----
// ----------------------------------------------------------------------------
// mec_mul
// Unsigned 64x64 multiplier built from one 32x32 multiplier and four partial products.
// ----------------------------------------------------------------------------
module mec_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [1:0]   k_reg, k_next;
    logic         iss_reg, iss_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   pk_reg, pk_next;
    logic         pv_reg, pv_next;
    logic [127:0] acc_reg, acc_next;
    logic         done_reg, done_next;
    logic [31:0]  ah, bh;
    logic [1:0]   sh;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        iss_next  = iss_reg;
        pp_next   = pp_reg;
        pk_next   = pk_reg;
        pv_next   = 1'b0;
        acc_next  = acc_reg;
        done_next = 1'b0;
        ah = k_reg[0] ? a_reg[63:32] : a_reg[31:0];
        bh = k_reg[1] ? b_reg[63:32] : b_reg[31:0];
        sh = {1'b0, pk_reg[0]} + {1'b0, pk_reg[1]};

        // Accumulate the partial product issued last cycle
        if (pv_reg) begin
            acc_next = acc_reg + ({64'd0, pp_reg} << {sh, 5'd0});
            if (pk_reg == 2'd3) begin
                done_next = 1'b1;
            end
        end

        // Issue one partial product per cycle
        if (iss_reg) begin
            pp_next = 64'(ah * bh);
            pk_next = k_reg;
            pv_next = 1'b1;
            k_next  = k_reg + 2'd1;
            if (k_reg == 2'd3) begin
                iss_next = 1'b0;
            end
        end

        if (start) begin
            a_next   = a;
            b_next   = b;
            k_next   = 2'd0;
            iss_next = 1'b1;
            acc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg  <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 2'd0;
        end else begin
            iss_reg  <= iss_next;
            pv_reg   <= pv_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        pk_reg  <= pk_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- src/mec_div.sv -----
// ----------------------------------------------------------------------------
// mec_div
// Restoring divider, one quotient bit per cycle, unsigned 76 by 13 bits.
// ----------------------------------------------------------------------------
module mec_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [75:0] num,
    input  logic [12:0] den,
    output logic        done,
    output logic [75:0] quo
);

    logic [75:0] num_reg, num_next;
    logic [12:0] den_reg, den_next;
    logic [12:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [13:0] trial;
    logic        qbit;

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, num_reg[75]};
        qbit  = (trial >= {1'b0, den_reg});

        // Shift in one dividend bit and subtract where it fits
        if (busy_reg) begin
            rem_next = qbit ? 13'(trial - {1'b0, den_reg}) : trial[12:0];
            num_next = {num_reg[74:0], qbit};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        if (start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = 7'd76;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// ----- src/mec_front.sv -----
// ----------------------------------------------------------------------------
// mec_front
// Input side: takes beats, drops unused opcodes, queues work for the back end.
// ----------------------------------------------------------------------------
module mec_front
    import mec_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OPCODE_W-1:0] s_opcode,
    input  logic [COLUMN_W-1:0] s_column,
    input  logic [ROW_W-1:0]    s_row,
    output logic                q_valid,
    output item_t               q_item,
    input  logic                q_ready
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    item_t       in_item;

    assign in_item = '{opcode: s_opcode, column: s_column, row: s_row};
    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Accept every beat; only real operations enter the queue
    assign push = s_valid && s_ready && (s_opcode != OP_NONE);
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- src/mec_back.sv -----
// ----------------------------------------------------------------------------
// mec_back
// Execution side: view updates, coordinate mapping, iteration and coloring.
// ----------------------------------------------------------------------------
module mec_back
    import mec_pkg::*;
#(
    parameter int IMAGE_WIDTH   = 640,
    parameter int IMAGE_HEIGHT  = 480,
    parameter int FRACTION_BITS = 60
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_ready,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [COLOR_W-1:0] res_red,
    output logic [COLOR_W-1:0] res_green,
    output logic [COLOR_W-1:0] res_blue,
    output logic [ITER_W-1:0]  res_count
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_ZOOM       = 4'd1;
    localparam logic [3:0] S_MAP_MUL    = 4'd2;
    localparam logic [3:0] S_MAP_DIV    = 4'd3;
    localparam logic [3:0] S_MAP_WAIT   = 4'd4;
    localparam logic [3:0] S_UPD1       = 4'd5;
    localparam logic [3:0] S_UPD2       = 4'd6;
    localparam logic [3:0] S_MUL        = 4'd7;
    localparam logic [3:0] S_MUL_WAIT   = 4'd8;
    localparam logic [3:0] S_CHECK      = 4'd9;
    localparam logic [3:0] S_SCALE_DIV  = 4'd10;
    localparam logic [3:0] S_SCALE_WAIT = 4'd11;
    localparam logic [3:0] S_CUBE1      = 4'd12;
    localparam logic [3:0] S_CUBE2      = 4'd13;
    localparam logic [3:0] S_DONE       = 4'd14;

    localparam cfg_t         CFG_RST   = cfg_reset(FRACTION_BITS);
    localparam int           LIM_SHIFT = 2 * FRACTION_BITS + 2;
    localparam logic [127:0] ESC_LIM   = 128'(1) << LIM_SHIFT;

    // Reciprocals for exact division of a 29-bit digit window by the image size
    localparam int     CD_KW = 29 + $clog2(IMAGE_WIDTH);
    localparam int     CD_KH = 29 + $clog2(IMAGE_HEIGHT);
    localparam longint CD_MW = ((longint'(1) << CD_KW) + longint'(IMAGE_WIDTH) - 1)
                               / longint'(IMAGE_WIDTH);
    localparam longint CD_MH = ((longint'(1) << CD_KH) + longint'(IMAGE_HEIGHT) - 1)
                               / longint'(IMAGE_HEIGHT);

    logic [3:0]                state_reg, state_next;
    logic signed [COORD_W-1:0] view_reg [4];
    logic signed [COORD_W-1:0] view_next [4];
    logic [1:0]                zcnt_reg, zcnt_next;
    logic                      axis_reg, axis_next;
    logic [COLUMN_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic                      mneg_reg, mneg_next;
    logic [79:0]               mmag_reg, mmag_next;
    logic [12:0]               crem_reg, crem_next;
    logic [15:0]               cq_reg, cq_next;
    logic [63:0]               cquo_reg, cquo_next;
    logic [2:0]                cdig_reg, cdig_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0] zx_reg, zx_next, zy_reg, zy_next;
    logic [127:0]              sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [127:0]              xyp_reg, xyp_next;
    logic                      xyneg_reg, xyneg_next;
    logic signed [128:0]       dre_reg, dre_next, dim_reg, dim_next;
    logic [1:0]                msel_reg, msel_next;
    logic [ITER_W-1:0]         j_reg, j_next;
    logic [16:0]               s_reg, s_next;
    logic [33:0]               sq_reg, sq_next;
    logic [50:0]               cube_reg, cube_next;
    logic                      ov_reg, ov_next;
    logic [COLOR_W-1:0]        red_reg, red_next, green_reg, green_next;
    logic [COLOR_W-1:0]        blue_reg, blue_next;
    logic [ITER_W-1:0]         cnt_reg, cnt_next;

    // Shared arithmetic units
    logic         mul_start, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_prod;
    logic         div_start, div_done;
    logic [75:0]  div_num, div_quo;
    logic [12:0]  div_den;

    // Datapath intermediates
    logic signed [COORD_W-1:0] zv, zc, mlo, mhi;
    logic signed [64:0]        zdiff, mspan;
    logic signed [81:0]        zprod, zsh;
    logic [10:0]               midx;
    logic signed [76:0]        mprod, mabs;
    logic [28:0]               cd_x, cd_qd;
    logic [30:0]               cd_m;
    logic [59:0]               cd_prod;
    logic [12:0]               cd_den;
    logic [75:0]               cd_quo;
    logic signed [SAT_W-1:0]   qsg;
    logic signed [128:0]       rsh, ish;
    logic [127:0]              msq;
    logic [24:0]               b255;
    logic [41:0]               g255;
    logic [58:0]               r255;

    mec_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    mec_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = ov_reg;
    assign res_red   = red_reg;
    assign res_green = green_reg;
    assign res_blue  = blue_reg;
    assign res_count = cnt_reg;

    // Operand selection for the shared units
    always_comb begin
        mul_start = (state_reg == S_MUL);
        mul_a     = (msel_reg == 2'd1) ? abs64(zy_reg) : abs64(zx_reg);
        mul_b     = (msel_reg == 2'd0) ? abs64(zx_reg) : abs64(zy_reg);
        div_start = (state_reg == S_SCALE_DIV);
        div_num   = {48'd0, cfg.max_iter - j_reg, 16'd0};
        div_den   = {1'b0, cfg.max_iter};
    end

    // Combinational datapath pieces
    always_comb begin
        // Zoom: v = c + floor((v - c) * factor / 2^16)
        zv    = view_reg[zcnt_reg];
        zc    = zcnt_reg[1] ? cfg.zoom_center_im : cfg.zoom_center_re;
        zdiff = {zv[63], zv} - {zc[63], zc};
        zprod = 82'(zdiff) * 82'($signed({1'b0, cfg.zoom_factor}));
        zsh   = zprod >>> 16;

        // Mapping: span times (index + 1)
        mlo   = axis_reg ? view_reg[2] : view_reg[0];
        mhi   = axis_reg ? view_reg[3] : view_reg[1];
        midx  = axis_reg ? ({2'b00, row_reg} + 11'd1) : ({1'b0, col_reg} + 11'd1);
        mspan = {mhi[63], mhi} - {mlo[63], mlo};
        mprod = 77'(mspan) * 77'($signed({1'b0, midx}));
        mabs  = mprod[76] ? -mprod : mprod;

        // Mapping division: one 16-bit quotient digit per pass through S_MAP_DIV and S_MAP_WAIT
        cd_den  = axis_reg ? 13'(IMAGE_HEIGHT) : 13'(IMAGE_WIDTH);
        cd_m    = axis_reg ? 31'(CD_MH) : 31'(CD_MW);
        cd_x    = {crem_reg, mmag_reg[79:64]};
        cd_prod = {31'd0, cd_x} * {29'd0, cd_m};
        cd_qd   = {13'd0, cq_reg} * {16'd0, cd_den};
        cd_quo  = {cquo_reg[59:0], cq_reg};
        qsg     = mneg_reg ? -$signed({54'd0, cd_quo}) : $signed({54'd0, cd_quo});

        // Iteration: floor-shift the combined products
        rsh = dre_reg >>> FRACTION_BITS;
        ish = dim_reg >>> (FRACTION_BITS - 1);
        msq = sqx_reg + sqy_reg;

        // Color: 255 times powers of scale
        b255 = {s_reg, 8'd0} - 25'(s_reg);
        g255 = {sq_reg, 8'd0} - 42'(sq_reg);
        r255 = {cube_reg, 8'd0} - 59'(cube_reg);
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        for (int i = 0; i < 4; i++) begin
            view_next[i] = view_reg[i];
        end
        zcnt_next  = zcnt_reg;
        axis_next  = axis_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        mneg_next  = mneg_reg;
        mmag_next  = mmag_reg;
        crem_next  = crem_reg;
        cq_next    = cq_reg;
        cquo_next  = cquo_reg;
        cdig_next  = cdig_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        zx_next    = zx_reg;
        zy_next    = zy_reg;
        sqx_next   = sqx_reg;
        sqy_next   = sqy_reg;
        xyp_next   = xyp_reg;
        xyneg_next = xyneg_reg;
        dre_next   = dre_reg;
        dim_next   = dim_reg;
        msel_next  = msel_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        sq_next    = sq_reg;
        cube_next  = cube_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        cnt_next   = cnt_reg;
        ov_next    = (ov_reg && res_ready) ? 1'b0 : ov_reg;

        case (state_reg)
            S_IDLE: begin
                col_next = q_item.column;
                row_next = q_item.row;
                if (q_valid) begin
                    case (q_item.opcode)
                        OP_RENDER: begin
                            axis_next  = 1'b0;
                            state_next = S_MAP_MUL;
                        end
                        OP_ZOOM: begin
                            zcnt_next  = 2'd0;
                            state_next = S_ZOOM;
                        end
                        OP_RESTART: begin
                            view_next[0] = cfg.start_re_min;
                            view_next[1] = cfg.start_re_max;
                            view_next[2] = cfg.start_im_min;
                            view_next[3] = cfg.start_im_max;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Move one bound per cycle toward the center
            S_ZOOM: begin
                view_next[zcnt_reg] = sat64(
                    {{(SAT_W-82){zsh[81]}}, zsh} + sx64(zc));
                zcnt_next = zcnt_reg + 2'd1;
                if (zcnt_reg == 2'd3) begin
                    state_next = S_IDLE;
                end
            end
            S_MAP_MUL: begin
                mneg_next  = mprod[76];
                mmag_next  = {4'd0, mabs[75:0]};
                crem_next  = '0;
                cquo_next  = '0;
                cdig_next  = 3'd0;
                state_next = S_MAP_DIV;
            end
            // Estimate the next quotient digit by reciprocal multiplication
            S_MAP_DIV: begin
                cq_next    = axis_reg ? cd_prod[CD_KH +: 16] : cd_prod[CD_KW +: 16];
                state_next = S_MAP_WAIT;
            end
            // Keep the remainder, shift in the digit, finish after five digits
            S_MAP_WAIT: begin
                crem_next = 13'(cd_x - cd_qd);
                mmag_next = {mmag_reg[63:0], 16'd0};
                cquo_next = {cquo_reg[47:0], cq_reg};
                cdig_next = cdig_reg + 3'd1;
                if (cdig_reg != 3'd4) begin
                    state_next = S_MAP_DIV;
                end else if (!axis_reg) begin
                    cx_next    = sat64(qsg + sx64(mlo));
                    axis_next  = 1'b1;
                    state_next = S_MAP_MUL;
                end else begin
                    cy_next    = sat64(qsg + sx64(mlo));
                    zx_next    = '0;
                    zy_next    = '0;
                    sqx_next   = '0;
                    sqy_next   = '0;
                    xyp_next   = '0;
                    xyneg_next = 1'b0;
                    j_next     = '0;
                    if (cfg.max_iter == '0) begin
                        s_next     = 17'h10000;
                        state_next = S_CUBE1;
                    end else begin
                        state_next = S_UPD1;
                    end
                end
            end
            // Combine the squares of the previous point
            S_UPD1: begin
                dre_next   = $signed({1'b0, sqx_reg}) - $signed({1'b0, sqy_reg});
                dim_next   = xyneg_reg ? -$signed({1'b0, xyp_reg})
                                       : $signed({1'b0, xyp_reg});
                state_next = S_UPD2;
            end
            S_UPD2: begin
                zx_next    = sat64({rsh[128], rsh} + sx64(cx_reg));
                zy_next    = sat64({ish[128], ish} + sx64(cy_reg));
                msel_next  = 2'd0;
                state_next = S_MUL;
            end
            S_MUL: begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (msel_reg)
                        2'd0: begin
                            sqx_next = mul_prod;
                        end
                        2'd1: begin
                            sqy_next = mul_prod;
                        end
                        default: begin
                            xyp_next   = mul_prod;
                            xyneg_next = zx_reg[63] ^ zy_reg[63];
                        end
                    endcase
                    msel_next  = msel_reg + 2'd1;
                    state_next = (msel_reg == 2'd2) ? S_CHECK : S_MUL;
                end
            end
            // Escape test on the new point; advance the count if it has not escaped
            S_CHECK: begin
                if (msq > ESC_LIM) begin
                    state_next = S_SCALE_DIV;
                end else begin
                    j_next = j_reg + 12'd1;
                    if (({1'b0, j_reg} + 13'd1) == {1'b0, cfg.max_iter}) begin
                        state_next = S_SCALE_DIV;
                    end else begin
                        state_next = S_UPD1;
                    end
                end
            end
            S_SCALE_DIV: begin
                state_next = S_SCALE_WAIT;
            end
            S_SCALE_WAIT: begin
                if (div_done) begin
                    s_next     = div_quo[16:0];
                    state_next = S_CUBE1;
                end
            end
            S_CUBE1: begin
                sq_next    = 34'(s_reg) * 34'(s_reg);
                state_next = S_CUBE2;
            end
            S_CUBE2: begin
                cube_next  = 51'(sq_reg) * 51'(s_reg);
                state_next = S_DONE;
            end
            // Hold until the output register is free
            S_DONE: begin
                if (!ov_reg || res_ready) begin
                    red_next   = r255[55:48];
                    green_next = g255[39:32];
                    blue_next  = b255[23:16];
                    cnt_next   = j_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ov_reg      <= 1'b0;
            view_reg[0] <= CFG_RST.start_re_min;
            view_reg[1] <= CFG_RST.start_re_max;
            view_reg[2] <= CFG_RST.start_im_min;
            view_reg[3] <= CFG_RST.start_im_max;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            for (int i = 0; i < 4; i++) begin
                view_reg[i] <= view_next[i];
            end
        end
        zcnt_reg  <= zcnt_next;
        axis_reg  <= axis_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        mneg_reg  <= mneg_next;
        mmag_reg  <= mmag_next;
        crem_reg  <= crem_next;
        cq_reg    <= cq_next;
        cquo_reg  <= cquo_next;
        cdig_reg  <= cdig_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        xyp_reg   <= xyp_next;
        xyneg_reg <= xyneg_next;
        dre_reg   <= dre_next;
        dim_reg   <= dim_next;
        msel_reg  <= msel_next;
        j_reg     <= j_next;
        s_reg     <= s_next;
        sq_reg    <= sq_next;
        cube_reg  <= cube_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        cnt_reg   <= cnt_next;
    end

endmodule

// ----- verif/tb_mandelbrot_escape_colorizer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_colorizer
// Self-checking bench for the escape-time colorizer.
// ----------------------------------------------------------------------------
// A queue-fed driver offers render, zoom, restart and unused beats; a
// bit-accurate predictor tracks the view window and the register file and
// computes each pixel at the moment its beat is taken. The monitor compares
// every result beat against the oldest predicted pixel. Register writes
// happen only while the block is drained. Random phases vary the view,
// the zoom settings and the iteration limit under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_colorizer;
    import mec_pkg::*;

    localparam int  FRAC      = 60;
    localparam int  IMG_W     = 640;
    localparam int  IMG_H     = 480;
    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam logic signed [129:0] WIDE_MAX = 130'sd9223372036854775807;
    localparam logic signed [129:0] WIDE_MIN = -130'sd9223372036854775808;
    localparam logic [129:0]        ESC_LIM  = 130'd1 << (2 * FRAC + 2);
    localparam longint unsigned     Q_UNIT   = 64'd1152921504606846; // 2^60 / 1000

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [ITER_W-1:0]  count;
    } pixel_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_idx = '0;
    logic [COORD_W-1:0]   cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OPCODE_W-1:0]  s_opcode = '0;
    logic [COLUMN_W-1:0]  s_column = '0;
    logic [ROW_W-1:0]     s_row = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COLOR_W-1:0]   m_red;
    logic [COLOR_W-1:0]   m_green;
    logic [COLOR_W-1:0]   m_blue;
    logic [ITER_W-1:0]    m_escape_count;

    mandelbrot_escape_colorizer #(
        .IMAGE_WIDTH(IMG_W), .IMAGE_HEIGHT(IMG_H), .FRACTION_BITS(FRAC)
    ) dut (.*);

    // Clock: 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Register file and view window as the block should hold them
    cfg_t                      regs;
    logic signed [COORD_W-1:0] win_re_min, win_re_max, win_im_min, win_im_max;

    item_t  pending_q[$];
    pixel_t pixel_q[$];
    item_t  offered;
    bit     offered_taken = 1'b0;
    int     n_pushed = 0;
    int     n_taken  = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     send_hold = 1'b0;
    int     recv_hold_left = 0;
    bit     failed = 1'b0;
    longint cycles = 0;

    function automatic logic signed [COORD_W-1:0] clamp64(input logic signed [129:0] v);
        if (v > WIDE_MAX) return WIDE_MAX[63:0];
        if (v < WIDE_MIN) return WIDE_MIN[63:0];
        return v[63:0];
    endfunction

    // Map a pixel index into the view, division rounding toward zero
    function automatic logic signed [COORD_W-1:0] place(
        input logic signed [COORD_W-1:0] lo, input logic signed [COORD_W-1:0] hi,
        input logic [10:0] idx, input int size);
        logic signed [129:0] span, k, sz, q;
        span = 130'(hi) - 130'(lo);
        k    = idx + 11'd1;
        sz   = size;
        q    = (span * k) / sz;
        return clamp64(q + 130'(lo));
    endfunction

    // Pull one bound toward the zoom center
    function automatic logic signed [COORD_W-1:0] pull(
        input logic signed [COORD_W-1:0] v, input logic signed [COORD_W-1:0] c);
        logic signed [129:0] d, f;
        d = 130'(v) - 130'(c);
        f = regs.zoom_factor;
        return clamp64(((d * f) >>> 16) + 130'(c));
    endfunction

    function automatic pixel_t shade(input logic [10:0] col, input logic [10:0] row);
        logic signed [COORD_W-1:0] cx, cy, zx, zy, nx, ny;
        logic signed [129:0]       sq, cr;
        logic [129:0]              ax, ay, mag;
        logic [63:0]               s, t;
        int                        j;
        pixel_t                    p;
        cx = place(win_re_min, win_re_max, col, IMG_W);
        cy = place(win_im_min, win_im_max, row, IMG_H);
        zx = '0;
        zy = '0;
        j  = 0;
        while (j < int'(regs.max_iter)) begin
            sq = 130'(zx) * 130'(zx) - 130'(zy) * 130'(zy);
            cr = 130'(zx) * 130'(zy);
            nx = clamp64((sq >>> FRAC) + 130'(cx));
            ny = clamp64((cr >>> (FRAC - 1)) + 130'(cy));
            zx = nx;
            zy = ny;
            ax = {66'b0, abs64(zx)};
            ay = {66'b0, abs64(zy)};
            mag = ax * ax + ay * ay;
            if (mag > ESC_LIM) break;
            j++;
        end
        if (regs.max_iter == '0) s = 64'd65536;
        else s = (64'(int'(regs.max_iter) - j) << 16) / 64'(regs.max_iter);
        t = 64'd255 * s * s * s;
        p.red = t[55:48];
        t = 64'd255 * s * s;
        p.green = t[39:32];
        t = 64'd255 * s;
        p.blue = t[23:16];
        p.count = ITER_W'(j);
        return p;
    endfunction

    // Advance the predicted state by one taken beat
    task automatic apply_item(input item_t it);
        case (it.opcode)
            OP_RENDER: pixel_q.push_back(shade({1'b0, it.column}, {2'b0, it.row}));
            OP_ZOOM: begin
                win_re_min = pull(win_re_min, regs.zoom_center_re);
                win_re_max = pull(win_re_max, regs.zoom_center_re);
                win_im_min = pull(win_im_min, regs.zoom_center_im);
                win_im_max = pull(win_im_max, regs.zoom_center_im);
            end
            OP_RESTART: begin
                win_re_min = regs.start_re_min;
                win_re_max = regs.start_re_max;
                win_im_min = regs.start_im_min;
                win_im_max = regs.start_im_max;
            end
            default: ;
        endcase
    endtask

    // Input side: hold the beat until taken, then offer the next one
    always @(negedge aclk) begin
        if (!s_valid || offered_taken) begin
            offered_taken = 1'b0;
            if (aresetn && !send_hold && pending_q.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                offered = pending_q.pop_front();
                s_valid  <= 1'b1;
                s_opcode <= offered.opcode;
                s_column <= offered.column;
                s_row    <= offered.row;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Output side: random stalls plus a counted long hold-off
    always @(negedge aclk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left = recv_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        pixel_t exp_px;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                offered_taken = 1'b1;
                apply_item(offered);
                n_taken++;
            end
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("result beat with no pixel pending");
                    failed = 1'b1;
                end else begin
                    exp_px = pixel_q.pop_front();
                    if (m_red !== exp_px.red) begin
                        $error("red: expected %0d, got %0d", exp_px.red, m_red);
                        failed = 1'b1;
                    end
                    if (m_green !== exp_px.green) begin
                        $error("green: expected %0d, got %0d", exp_px.green, m_green);
                        failed = 1'b1;
                    end
                    if (m_blue !== exp_px.blue) begin
                        $error("blue: expected %0d, got %0d", exp_px.blue, m_blue);
                        failed = 1'b1;
                    end
                    if (m_escape_count !== exp_px.count) begin
                        $error("escape_count: expected %0d, got %0d",
                               exp_px.count, m_escape_count);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push(input logic [OPCODE_W-1:0] op, input int col, input int row);
        item_t it;
        it.opcode = op;
        it.column = COLUMN_W'(col);
        it.row    = ROW_W'(row);
        pending_q.push_back(it);
        n_pushed++;
    endtask

    // Wait until every beat is taken and every pixel has come out
    task automatic drain();
        while (n_taken != n_pushed || pixel_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= data;
        case (idx)
            CFG_ZOOM_CENTER_RE: regs.zoom_center_re = data;
            CFG_ZOOM_CENTER_IM: regs.zoom_center_im = data;
            CFG_START_RE_MIN:   regs.start_re_min   = data;
            CFG_START_RE_MAX:   regs.start_re_max   = data;
            CFG_START_IM_MIN:   regs.start_im_min   = data;
            CFG_START_IM_MAX:   regs.start_im_max   = data;
            CFG_ZOOM_FACTOR:    regs.zoom_factor    = data[ZF_W-1:0];
            default:            regs.max_iter       = data[ITER_W-1:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] near_coord();
        longint m;
        m = longint'($urandom_range(0, 5000)) - 2500;
        return 64'(m * longint'(Q_UNIT));
    endfunction

    function automatic logic [63:0] any_coord();
        return {$urandom, $urandom};
    endfunction

    // New view, zoom settings and limit; wide ones push the math to saturation
    task automatic shuffle_regs(input bit wide);
        logic [63:0] lo_re, lo_im;
        lo_re = wide ? any_coord() : near_coord();
        lo_im = wide ? any_coord() : near_coord();
        cfg_write(CFG_ZOOM_CENTER_RE, wide ? any_coord() : near_coord());
        cfg_write(CFG_ZOOM_CENTER_IM, wide ? any_coord() : near_coord());
        cfg_write(CFG_START_RE_MIN, lo_re);
        cfg_write(CFG_START_RE_MAX, wide ? any_coord() : lo_re + near_coord());
        cfg_write(CFG_START_IM_MIN, lo_im);
        cfg_write(CFG_START_IM_MAX, wide ? any_coord() : lo_im + near_coord());
        cfg_write(CFG_ZOOM_FACTOR, {$urandom, $urandom});
        cfg_write(CFG_MAX_ITER, {52'b0, 12'($urandom_range(1, 24))} |
                  {$urandom, 20'b0, 12'b0});
    endtask

    task automatic random_items(input int n);
        int pick, col, row;
        push(OP_RESTART, $urandom_range(0, 1023), $urandom_range(0, 511));
        for (int i = 1; i < n; i++) begin
            pick = $urandom_range(99);
            col = ($urandom_range(7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 639);
            row = ($urandom_range(7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 479);
            if (pick < 72)      push(OP_RENDER, col, row);
            else if (pick < 86) push(OP_ZOOM, col, row);
            else if (pick < 94) push(OP_RESTART, col, row);
            else                push(OP_NONE, col, row);
        end
    endtask

    initial begin
        regs.zoom_center_re = 64'sd0;
        regs.zoom_center_im = 64'sd1 <<< FRAC;
        regs.start_re_min   = -(64'sd5 <<< (FRAC - 1));
        regs.start_re_max   = 64'sd1 <<< FRAC;
        regs.start_im_min   = -(64'sd3 <<< (FRAC - 1));
        regs.start_im_max   = 64'sd3 <<< (FRAC - 1);
        regs.zoom_factor    = 16'd58982;
        regs.max_iter       = 12'd50;
        win_re_min = regs.start_re_min;
        win_re_max = regs.start_re_max;
        win_im_min = regs.start_im_min;
        win_im_max = regs.start_im_max;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: corners, out-of-image indexes, all opcodes at reset values
        push(OP_RENDER, 0, 0);
        push(OP_RENDER, 639, 479);
        push(OP_RENDER, 1023, 511);
        push(OP_RENDER, 320, 240);
        push(OP_ZOOM, 0, 0);
        push(OP_RENDER, 320, 240);
        push(OP_NONE, 1023, 511);
        push(OP_RESTART, 0, 0);
        push(OP_RENDER, 459, 240);
        drain();

        // Zero iteration limit gives a white pixel
        cfg_write(CFG_MAX_ITER, 64'd0);
        push(OP_RENDER, 100, 100);
        drain();

        // Largest limit: one quick escape, one point that never escapes
        cfg_write(CFG_MAX_ITER, 64'd4095);
        push(OP_RENDER, 0, 0);
        push(OP_RENDER, 459, 240);
        drain();

        // Zoom factor extremes
        cfg_write(CFG_MAX_ITER, 64'd12);
        cfg_write(CFG_ZOOM_FACTOR, 64'd0);
        push(OP_ZOOM, 0, 0);
        push(OP_RENDER, 639, 479);
        drain();
        cfg_write(CFG_ZOOM_FACTOR, 64'hFFFF);
        push(OP_RESTART, 0, 0);
        push(OP_ZOOM, 0, 0);
        push(OP_RENDER, 1, 1);
        drain();

        // Extreme view bounds and centers force saturation everywhere
        cfg_write(CFG_START_RE_MIN, 64'h8000_0000_0000_0000);
        cfg_write(CFG_START_RE_MAX, 64'h7FFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_START_IM_MIN, 64'h7FFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_START_IM_MAX, 64'h8000_0000_0000_0000);
        cfg_write(CFG_ZOOM_CENTER_RE, 64'h7FFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_ZOOM_CENTER_IM, 64'h8000_0000_0000_0000);
        push(OP_RESTART, 0, 0);
        push(OP_RENDER, 0, 0);
        push(OP_RENDER, 1023, 511);
        push(OP_ZOOM, 0, 0);
        push(OP_RENDER, 320, 240);
        drain();

        // Random phases under three back-pressure profiles
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin send_idle_pct = 15; recv_idle_pct = 74; end
                1: begin send_idle_pct = 74; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            shuffle_regs(ph % 4 == 3);
            random_items(90);
            if (ph == 1) begin
                // Stall the output long enough for the input to back up
                @(posedge aclk);
                recv_hold_left = 4000;
            end
            if (ph == 4) begin
                // Let the block run dry before offering more
                while (pending_q.size() > 45) @(posedge aclk);
                send_hold = 1'b1;
                while (n_taken != n_pushed - pending_q.size() || pixel_q.size() != 0)
                    @(posedge aclk);
                send_hold = 1'b0;
            end
            random_items(90);
            drain();
        end

        repeat (100) @(posedge aclk);
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
